@@ rtl/lce_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and register map of the line convolution block
package lce_pkg;

   localparam int NUM_COEF       = 7;
   localparam int COEF_W         = 16;
   localparam int PIX_W          = 8;
   localparam int NUM_LANES      = 3;
   localparam int RADIUS_W       = 2;
   localparam int DEF_MAX_RADIUS = 3;
   localparam int DEF_CHANNELS   = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int PROD_W         = PIX_W + COEF_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_TAP_RADIUS = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_0     = 3'd1;

   localparam logic [RADIUS_W-1:0] RESET_RADIUS = 2'd1;
   localparam logic [NUM_COEF-1:0][COEF_W-1:0] RESET_COEF = {
      16'd0, 16'd0, 16'd0, 16'd16384, 16'd32768, 16'd16384, 16'd0
   };

   // lane 0 red, lane 1 green, lane 2 blue
   typedef logic [NUM_LANES-1:0][PIX_W-1:0] lce_pixel_type;

   typedef struct packed {
      logic [RADIUS_W-1:0]                tap_radius;
      logic [NUM_COEF-1:0][COEF_W-1:0]    coef;
   } lce_cfg_type;

   typedef struct packed {
      logic                last;
      logic [RADIUS_W-1:0] radius;
   } lce_desc_type;

endpackage

@@ rtl/lce_csr.sv @@
`timescale 1ns / 1ps
// configuration registers behind the apb-style port
module lce_csr import lce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output lce_cfg_type           cfg
);

   lce_cfg_type          cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [REG_IDX_W-1:0] coef_idx;
   logic                 wr_en;

   assign reg_idx  = paddr[CSR_ADDR_W-1:2];
   assign coef_idx = reg_idx - REG_COEF_0;
   assign wr_en    = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         if (reg_idx == REG_TAP_RADIUS) begin
            cfg_in.tap_radius = pwdata[RADIUS_W-1:0];
         end else begin
            cfg_in.coef[coef_idx] = pwdata[COEF_W-1:0];
         end
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TAP_RADIUS: begin
            prdata = {{(CSR_DATA_W-RADIUS_W){1'b0}}, cfg_ff.tap_radius};
         end
         default: begin
            prdata = {{(CSR_DATA_W-COEF_W){1'b0}}, cfg_ff.coef[coef_idx]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_radius <= RESET_RADIUS;
         cfg_ff.coef       <= RESET_COEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/lce_front.sv @@
`timescale 1ns / 1ps
// input side: pixel window, line position and classification of each pixel
module lce_front import lce_pkg::*; #(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   localparam int WIN = 2 * MAX_RADIUS + 1,
   localparam int CNT_W = $clog2(WIN)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lce_pixel_type           pixel,
   input  logic                    line_end,
   input  logic [RADIUS_W-1:0]     tap_radius,
   input  logic                    q_full,
   output logic                    push,
   output lce_desc_type            desc,
   output logic [CNT_W-1:0]        seen,
   output lce_pixel_type [WIN-1:0] win
);

   localparam int R_TOP = (1 << RADIUS_W) - 1;
   localparam int R_LIM = (MAX_RADIUS < R_TOP) ? MAX_RADIUS : R_TOP;
   localparam logic [RADIUS_W-1:0] R_LIM_V  = RADIUS_W'(R_LIM);
   localparam logic [CNT_W-1:0]    SEEN_MAX = CNT_W'(2 * MAX_RADIUS);

   lce_pixel_type [WIN-1:0] win_ff, win_in;
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic [RADIUS_W-1:0]     radius;
   logic                    accept;

   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;
   assign radius    = (tap_radius > R_LIM_V) ? R_LIM_V : tap_radius;
   assign push      = accept & (line_end | (seen_ff >= CNT_W'(radius)));

   assign desc.last   = line_end;
   assign desc.radius = radius;
   assign seen        = seen_ff;
   assign win         = win_in;

   always_comb begin
      win_in[0] = pixel;
      for (int i = 1; i < WIN; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (line_end) begin
            seen_in = '0;
         end else if (seen_ff < SEEN_MAX) begin
            seen_in = seen_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

@@ rtl/lce_queue.sv @@
`timescale 1ns / 1ps
// short fifo between the front and back parts
module lce_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output logic [DATA_W-1:0] rd_data
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_FULL);
   assign valid   = (count_ff != '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL) else $error("queue count beyond depth");
`endif

endmodule

@@ rtl/lce_back.sv @@
`timescale 1ns / 1ps
// output side: per-result sequencer, tap select, multiply lanes, sum and saturate
module lce_back import lce_pkg::*; #(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int CHANNELS = DEF_CHANNELS,
   localparam int WIN = 2 * MAX_RADIUS + 1,
   localparam int CNT_W = $clog2(WIN)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  lce_desc_type                    desc,
   input  logic [CNT_W-1:0]                seen,
   input  lce_pixel_type [WIN-1:0]         win,
   input  logic [NUM_COEF-1:0][COEF_W-1:0] coef,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lce_pixel_type                   rsp_pixel,
   output logic                            rsp_line_end
);

   localparam int ACT_CH = (CHANNELS < NUM_LANES) ? CHANNELS : NUM_LANES;
   localparam int T_W    = RADIUS_W + 1;
   localparam int CMP_W  = (CNT_W > T_W) ? CNT_W : T_W;
   localparam int ACC_W  = PROD_W + $clog2(NUM_COEF);
   localparam int HI_W   = ACC_W - COEF_W;

   // sequencer
   logic                busy_ff, busy_in;
   logic [RADIUS_W-1:0] lag_ff, lag_in;
   logic [RADIUS_W-1:0] lag, lag_start;
   logic                adv, issue, final_out;

   // tap select
   logic [T_W-1:0]                  tap_sum;
   logic [T_W-1:0]                  t_val [NUM_COEF];
   logic [CMP_W-1:0]                idx_c [NUM_COEF];
   lce_pixel_type [NUM_COEF-1:0]    s1_pix_ff, s1_pix_in;
   logic [NUM_COEF-1:0][COEF_W-1:0] s1_wt_ff, s1_wt_in;
   logic                            s1_valid_ff, s1_last_ff;

   // multiply lanes
   logic [PROD_W-1:0] s2_prod_ff [NUM_COEF][ACT_CH];
   logic [PROD_W-1:0] s2_prod_in [NUM_COEF][ACT_CH];
   logic              s2_valid_ff, s2_last_ff;

   // output register
   lce_pixel_type rsp_pixel_ff, rsp_pixel_in;
   logic          rsp_valid_ff, rsp_line_end_ff;

   assign adv = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      lag_start = desc.radius;
      if (desc.last && (seen < CNT_W'(desc.radius))) begin
         lag_start = seen[RADIUS_W-1:0];
      end
      lag       = busy_ff ? lag_ff : lag_start;
      final_out = ~desc.last | (lag == '0);
      issue     = adv & q_valid;
      pop       = issue & final_out;
      busy_in   = busy_ff;
      lag_in    = lag_ff;
      if (issue) begin
         busy_in = ~final_out;
         lag_in  = lag - RADIUS_W'(1);
      end
   end

   always_comb begin
      tap_sum = T_W'(lag) + T_W'(desc.radius);
      for (int j = 0; j < NUM_COEF; j++) begin
         if (tap_sum < T_W'(j)) begin
            t_val[j] = '0;
         end else begin
            t_val[j] = tap_sum - T_W'(j);
         end
         idx_c[j] = CMP_W'(t_val[j]);
         if (idx_c[j] > CMP_W'(seen)) begin
            idx_c[j] = CMP_W'(seen);
         end
         if (idx_c[j] > CMP_W'(WIN - 1)) begin
            idx_c[j] = CMP_W'(WIN - 1);
         end
         s1_pix_in[j] = win[idx_c[j][CNT_W-1:0]];
         s1_wt_in[j]  = (T_W'(j) <= {desc.radius, 1'b0}) ? coef[j] : '0;
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_COEF; j++) begin
         for (int c = 0; c < ACT_CH; c++) begin
            s2_prod_in[j][c] = s1_pix_ff[j][c] * s1_wt_ff[j];
         end
      end
   end

   for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
      if (c < ACT_CH) begin : g_act
         logic [ACC_W-1:0] acc;
         logic [HI_W-1:0]  hi;
         always_comb begin
            acc = '0;
            for (int j = 0; j < NUM_COEF; j++) begin
               acc = acc + ACC_W'(s2_prod_ff[j][c]);
            end
         end
         assign hi = acc[ACC_W-1:COEF_W];
         assign rsp_pixel_in[c] = (|hi[HI_W-1:PIX_W]) ? {PIX_W{1'b1}} : hi[PIX_W-1:0];
      end else begin : g_zero
         assign rsp_pixel_in[c] = '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixel    = rsp_pixel_ff;
   assign rsp_line_end = rsp_line_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         lag_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         lag_ff  <= lag_in;
         if (adv) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pix_ff       <= s1_pix_in;
         s1_wt_ff        <= s1_wt_in;
         s1_last_ff      <= desc.last & (lag == '0);
         s2_prod_ff      <= s2_prod_in;
         s2_last_ff      <= s1_last_ff;
         rsp_pixel_ff    <= rsp_pixel_in;
         rsp_line_end_ff <= s2_last_ff;
      end
   end

`ifndef SYNTH
   a_busy_on_line_end: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (q_valid && desc.last)) else $error("flush without a line end entry");
   a_busy_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (issue && !final_out) |=> busy_ff) else $error("flush sequence dropped");
   a_lag_below_radius: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (lag_ff < desc.radius)) else $error("flush distance out of range");
`endif

endmodule

@@ rtl/line_convolution_edge_clamped.sv @@
`timescale 1ns / 1ps
// top level of the edge-clamped line convolution
//
//   channel   ports               direction   meaning
//   req       req_valid/ready     in          one rgb pixel per transfer, line end flag
//   rsp       rsp_valid/ready     out         one filtered pixel per transfer
//   csr       psel..pready        in/out      tap radius and seven tap weights
//
// one pixel per clock is taken while the queue is not full; a pixel inside the line gives
// at most one result, the line end pixel gives up to radius+1 results, one per clock from the
// back sequencer unless rsp stalls; results pass tap select, multiply, sum and saturate registers.
// a four-entry queue parts the window front from the multiply back; req_ready drops when full.
// synchronous reset clears control state and loads the register defaults.
module line_convolution_edge_clamped import lce_pkg::*; #(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_red_in,
   input  logic [PIX_W-1:0]      req_green_in,
   input  logic [PIX_W-1:0]      req_blue_in,
   input  logic                  req_line_end_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_red_out,
   output logic [PIX_W-1:0]      rsp_green_out,
   output logic [PIX_W-1:0]      rsp_blue_out,
   output logic                  rsp_line_end_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int WIN    = 2 * MAX_RADIUS + 1;
   localparam int CNT_W  = $clog2(WIN);
   localparam int DATA_W = $bits(lce_desc_type) + CNT_W + WIN * $bits(lce_pixel_type);

   lce_cfg_type             cfg;
   lce_pixel_type           in_pixel, out_pixel;
   logic                    q_full, q_valid, q_push, q_pop;
   lce_desc_type            f_desc, b_desc;
   logic [CNT_W-1:0]        f_seen, b_seen;
   lce_pixel_type [WIN-1:0] f_win, b_win;
   logic [DATA_W-1:0]       q_wr_data, q_rd_data;

   assign in_pixel[0] = req_red_in;
   assign in_pixel[1] = req_green_in;
   assign in_pixel[2] = req_blue_in;

   assign rsp_red_out   = out_pixel[0];
   assign rsp_green_out = out_pixel[1];
   assign rsp_blue_out  = out_pixel[2];

   assign q_wr_data = {f_desc, f_seen, f_win};
   assign {b_desc, b_seen, b_win} = q_rd_data;

   lce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lce_front #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .pixel      (in_pixel),
      .line_end   (req_line_end_in),
      .tap_radius (cfg.tap_radius),
      .q_full     (q_full),
      .push       (q_push),
      .desc       (f_desc),
      .seen       (f_seen),
      .win        (f_win)
   );

   lce_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .full    (q_full),
      .valid   (q_valid),
      .rd_data (q_rd_data)
   );

   lce_back #(
      .MAX_RADIUS (MAX_RADIUS),
      .CHANNELS   (CHANNELS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .desc         (b_desc),
      .seen         (b_seen),
      .win          (b_win),
      .coef         (cfg.coef),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel    (out_pixel),
      .rsp_line_end (rsp_line_end_out)
   );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for the edge-clamped line convolution: random kernels, lines and stalls
module testbench;
   import lce_pkg::*;

   localparam int WIN_DEPTH    = 2 * DEF_MAX_RADIUS + 1;
   localparam int DRAIN_CYCLES = 12;
   localparam int TOTAL_PIXELS = 155;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             line_end;
   } blur_pixel_type;

   class line_blur_model;
      lce_pixel_type  window [WIN_DEPTH];
      int unsigned    seen;
      int unsigned    radius;
      int unsigned    coef [NUM_COEF];
      blur_pixel_type expected_pixels [$];
      int             errors;

      function new();
         int j;
         radius = RESET_RADIUS;
         for (j = 0; j < NUM_COEF; j++) coef[j] = RESET_COEF[j];
         for (j = 0; j < WIN_DEPTH; j++) window[j] = '0;
         seen = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_TAP_RADIUS) begin
            radius = value[RADIUS_W-1:0];
         end else begin
            coef[idx - REG_COEF_0] = value[COEF_W-1:0];
         end
      endfunction

      function logic [PIX_W-1:0] tap_sum(int d, int r, int p, int lane);
         int unsigned acc;
         int          idx;
         int          j;
         acc = 0;
         for (j = 0; j <= 2 * r; j++) begin
            idx = d + r - j;
            if (idx < 0) idx = 0;
            if (idx > p) idx = p;
            if (idx >= WIN_DEPTH) idx = WIN_DEPTH - 1;
            acc += int'(window[idx][lane]) * coef[j];
         end
         acc = acc >> 16;
         return (acc > 255) ? 8'd255 : 8'(acc);
      endfunction

      function void push_pixel(int d, int r, int p, logic last);
         blur_pixel_type res;
         res.red      = tap_sum(d, r, p, 0);
         res.green    = tap_sum(d, r, p, 1);
         res.blue     = tap_sum(d, r, p, 2);
         res.line_end = last;
         expected_pixels = {expected_pixels, res};
      endfunction

      function void take_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                               logic [PIX_W-1:0] blue, logic line_end);
         int r;
         int p;
         int d;
         int k;
         r = (radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius;
         p = seen;
         for (k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = {blue, green, red};
         if (!line_end) begin
            if (p >= r) push_pixel(r, r, p, 1'b0);
            if (seen < 2 * DEF_MAX_RADIUS) seen++;
         end else begin
            d = (p < r) ? p : r;
            while (d >= 0) begin
               push_pixel(d, r, p, d == 0);
               d--;
            end
            seen = 0;
         end
      endfunction

      function void match_pixel(blur_pixel_type got);
         blur_pixel_type want;
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel red %0d green %0d blue %0d line_end %0d",
                   got.red, got.green, got.blue, got.line_end);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.red !== want.red) begin
            $error("red_out expected %0d got %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green_out expected %0d got %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue_out expected %0d got %0d", want.blue, got.blue);
            errors++;
         end
         if (got.line_end !== want.line_end) begin
            $error("line_end_out expected %0d got %0d", want.line_end, got.line_end);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_red_in = '0;
   logic [PIX_W-1:0]      req_green_in = '0;
   logic [PIX_W-1:0]      req_blue_in = '0;
   logic                  req_line_end_in = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_red_out;
   logic [PIX_W-1:0]      rsp_green_out;
   logic [PIX_W-1:0]      rsp_blue_out;
   logic                  rsp_line_end_out;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   line_blur_model model = new();
   int unsigned    kernel [NUM_COEF];
   int             pixels_sent = 0;
   bit             sender_fast = 1'b0;
   bit             receiver_fast = 1'b0;

   line_convolution_edge_clamped uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_line_end_in  (req_line_end_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_line_end_out (rsp_line_end_out),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin : transfer_monitor
      blur_pixel_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_line_end_out};
         model.match_pixel(got);
      end
      if (!reset && req_valid && req_ready) begin
         model.take_pixel(req_red_in, req_green_in, req_blue_in, req_line_end_in);
      end
   end

   // result side back-pressure
   initial begin : receiver
      int stall;
      forever begin
         stall = receiver_fast ? 0 : $urandom_range(0, 14);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if ($urandom_range(0, 15) == 0) receiver_fast = !receiver_fast;
      end
   end

   task automatic send_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                             logic [PIX_W-1:0] blue, logic last);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_red_in      <= red;
      req_green_in    <= green;
      req_blue_in     <= blue;
      req_line_end_in <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      pixels_sent++;
   endtask

   function automatic logic [PIX_W-1:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_line(int len);
      int i;
      for (i = 0; i < len; i++) begin
         send_pixel(pick_channel(), pick_channel(), pick_channel(), i == len - 1);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model.write_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic program_kernel(int unsigned radius);
      int j;
      write_csr(REG_TAP_RADIUS, radius);
      for (j = 0; j < NUM_COEF; j++) begin
         write_csr(REG_COEF_0 + REG_IDX_W'(j), kernel[j]);
      end
   endtask

   initial begin : stimulus
      int j;
      int lines;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // default kernel, single pixel and short lines
      send_pixel(8'd255, 8'd0, 8'd165, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd90, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd128, 8'd1, 1'b1);

      // widest kernel, full-scale taps saturate
      wait_idle();
      for (j = 0; j < NUM_COEF; j++) kernel[j] = 16'hffff;
      program_kernel(3);
      send_pixel(8'd200, 8'd100, 8'd50, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd17, 8'd34, 8'd51, 1'b1);
      send_line(4);
      send_line(7);

      // radius zero passes a single tap
      wait_idle();
      kernel[0] = 16'hffff;
      for (j = 1; j < NUM_COEF; j++) kernel[j] = 0;
      program_kernel(0);
      send_pixel(8'd255, 8'd254, 8'd1, 1'b0);
      send_pixel(8'd128, 8'd127, 8'd0, 1'b1);

      while (pixels_sent < TOTAL_PIXELS) begin
         wait_idle();
         for (j = 0; j < NUM_COEF; j++) begin
            case ($urandom_range(0, 7))
               0: kernel[j] = 0;
               1: kernel[j] = 16'hffff;
               2, 3: kernel[j] = $urandom_range(0, 65535);
               default: kernel[j] = $urandom_range(0, 24000);
            endcase
         end
         program_kernel($urandom_range(0, 3));
         lines = $urandom_range(2, 5);
         repeat (lines) begin
            sender_fast = ($urandom_range(0, 3) == 0);
            send_line(($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 14));
         end
      end

      wait_idle();
      if (model.errors == 0 && model.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
